// ===== rtl/pfv_pkg.sv =====
// pfv_pkg: shared types and constants of the pcm fade and volume block
// used by pfv_div, pfv_mul, pfv_checker and pcm_fade_and_volume_top; has no dependencies

package pfv_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT = 3'd4;

  // arithmetic constants
  localparam logic [7:0] CENTRE     = 8'd127;
  localparam logic [9:0] FADE_ROUND = 10'd999;
  localparam logic [9:0] MS_PER_S   = 10'd1000;
  localparam logic [6:0] PCT        = 7'd100;
  localparam logic [6:0] VOL_MAX    = 7'd100;
  localparam logic [2:0] MIN_CLIP   = 3'd4;

  // fade length never exceeds ceil(65535 * 255 / 1000)
  localparam int unsigned FADE_W = 15;

  // shared multiplier
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // shared divider
  localparam int unsigned DIV_NUM_W = 24;
  localparam int unsigned DIV_DEN_W = FADE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);
  // dividend widths of the three divisions
  localparam int unsigned FADE_DIV_BITS = DIV_NUM_W;
  localparam int unsigned ENV_DIV_BITS  = 22;
  localparam int unsigned VOL_DIV_BITS  = 14;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] top_bit;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FADE_MUL,
    ST_FADE_DIV,
    ST_ENV_MUL,
    ST_ENV_DIV,
    ST_VOL_MUL,
    ST_VOL_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/pcm_fade_and_volume_top.sv =====
// pcm_fade_and_volume_top: fade envelope and volume gain for 8-bit pcm clips
// depends on pfv_pkg, pfv_mul and pfv_div
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  s_axis   | in        | tvalid / tready       | tdata: sample; tuser: first_sample
//  m_axis   | out       | tvalid / tready       | tdata: level; tuser: speaker_high;
//           |           |                       | tlast: clip_done
//  cfg      | in        | cfg_we_i (no wait)    | cfg_index_i, cfg_data_i
//
// one request is in flight at a time; the one-bit-per-cycle divider sets the rate:
// with the envelope active a request runs a 22-bit envelope division and a 14-bit
// volume division; bypassed or at full scale it runs only the volume division
// the first request after a write to sample_rate, fade_ms or clip_length first
// recomputes the fade length (24-bit division by 1000)
// a finished result waits in the output register while the next request is taken
// reset is asynchronous active low and restores the register defaults and position 0

module pcm_fade_and_volume_top #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [pfv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfv_pkg::CFG_W-1:0]        cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] sample
  input  logic                             s_axis_tuser,  // [0] first_sample
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] level
  output logic                             m_axis_tuser,  // [0] speaker_high
  output logic                             m_axis_tlast   // clip_done
);
  import pfv_pkg::*;

  // common width for position against clip length compares
  localparam int unsigned CW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

  // config registers
  logic [6:0]        vol_q;
  logic [15:0]       rate_q;
  logic [7:0]        fms_q;
  logic [CFG_W-1:0]  clip_q;
  logic              direct_q;
  logic              cfg_clear;

  // cached fade length
  logic [FADE_W-1:0] fade_q, fade_d;
  logic              fade_ok_q, fade_ok_d;

  // sequencer and per-request state
  state_e                 state_q, state_d;
  logic                   go_q, go_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LENGTH_BITS-1:0] pos_cur_q, pos_cur_d;
  logic [7:0]             smp_q, smp_d;
  logic                   last_q, last_d;
  logic [7:0]             env_q, env_d;
  logic [7:0]             lvl_q, lvl_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_level_q, out_level_d;
  logic       out_spk_q, out_spk_d;
  logic       out_last_q, out_last_d;

  // shared units
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // envelope helpers
  logic [LENGTH_BITS-1:0] pos_eff;
  logic                   done_eff;
  logic [CW-1:0]          pos_ext, clip_ext, fade_ext, left, kmin;
  logic [22:0]            half;
  logic                   bypass, full;
  logic                   neg_s, neg_e;
  logic [7:0]             mag_s, mag_e, quo8;

  pfv_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pfv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // config writes; a volume field (bits 6:0) above 100 saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q    <= VOL_MAX;
      rate_q   <= 16'd8000;
      fms_q    <= 8'd4;
      clip_q   <= '0;
      direct_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VOLUME: vol_q <= (cfg_data_i[6:0] > VOL_MAX) ? VOL_MAX : cfg_data_i[6:0];
        REG_RATE:   rate_q   <= cfg_data_i[15:0];
        REG_FADE:   fms_q    <= cfg_data_i[7:0];
        REG_CLIP:   clip_q   <= cfg_data_i;
        REG_DIRECT: direct_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // any write that changes the fade length drops the cached value
  assign cfg_clear = cfg_we_i &&
                     (cfg_index_i == REG_RATE || cfg_index_i == REG_FADE ||
                      cfg_index_i == REG_CLIP);

  // position bookkeeping for the incoming request
  always_comb begin
    pos_eff  = s_axis_tuser ? '0 : pos_q;
    done_eff = ({1'b0, CW'(pos_eff)} + 1'b1) >= {1'b0, CW'(clip_q)};
  end

  // envelope factor: k = min(fade, pos, left), bypass and full-scale tests
  always_comb begin
    half     = clip_q[CFG_W-1:1];
    pos_ext  = CW'(pos_cur_q);
    clip_ext = CW'(clip_q);
    fade_ext = CW'(fade_q);
    // past the end of the clip nothing is left
    left     = (pos_ext < clip_ext) ? (clip_ext - pos_ext - 1'b1) : '0;
    kmin     = fade_ext;
    if (pos_ext < kmin) kmin = pos_ext;
    if (left < kmin) kmin = left;
    full     = kmin >= fade_ext;
    bypass   = (rate_q == '0) || (clip_q < CFG_W'(MIN_CLIP)) || (fade_q == '0);
    neg_s    = smp_q < CENTRE;
    mag_s    = neg_s ? (CENTRE - smp_q) : (smp_q - CENTRE);
    neg_e    = env_q < CENTRE;
    mag_e    = neg_e ? (CENTRE - env_q) : (env_q - CENTRE);
    // quotient never exceeds the deviation it came from
    quo8     = div_rsp.quo[7:0];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    go_d        = 1'b0;
    pos_d       = pos_q;
    pos_cur_d   = pos_cur_q;
    smp_d       = smp_q;
    last_d      = last_q;
    env_d       = env_q;
    lvl_d       = lvl_q;
    fade_d      = fade_q;
    fade_ok_d   = fade_ok_q;
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    out_spk_d   = out_spk_q;
    out_last_d  = out_last_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    s_axis_tready = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          smp_d     = s_axis_tdata;
          pos_cur_d = pos_eff;
          last_d    = done_eff;
          pos_d     = done_eff ? '0 : (pos_eff + 1'b1);
          state_d   = (fade_ok_q && !cfg_clear) ? ST_ENV_MUL : ST_FADE_MUL;
        end
      end
      ST_FADE_MUL: begin
        mul_a   = rate_q;
        mul_b   = MUL_W'(fms_q);
        go_d    = 1'b1;
        state_d = ST_FADE_DIV;
      end
      ST_FADE_DIV: begin
        // ceil(rate * ms / 1000)
        div_req.start   = go_q;
        div_req.num     = DIV_NUM_W'(prod + PROD_W'(FADE_ROUND));
        div_req.den     = DIV_DEN_W'(MS_PER_S);
        div_req.top_bit = DIV_CNT_W'(FADE_DIV_BITS - 1);
        if (div_rsp.done) begin
          fade_d    = (div_rsp.quo > DIV_NUM_W'(half)) ? half[FADE_W-1:0]
                                                        : div_rsp.quo[FADE_W-1:0];
          fade_ok_d = 1'b1;
          state_d   = ST_ENV_MUL;
        end
      end
      ST_ENV_MUL: begin
        if (bypass || full) begin
          env_d   = smp_q;
          state_d = ST_VOL_MUL;
        end else begin
          mul_a   = MUL_W'(mag_s);
          mul_b   = MUL_W'(kmin[FADE_W-1:0]);
          go_d    = 1'b1;
          state_d = ST_ENV_DIV;
        end
      end
      ST_ENV_DIV: begin
        div_req.start   = go_q;
        div_req.num     = DIV_NUM_W'(prod);
        div_req.den     = fade_q;
        div_req.top_bit = DIV_CNT_W'(ENV_DIV_BITS - 1);
        if (div_rsp.done) begin
          env_d   = neg_s ? (CENTRE - quo8) : (CENTRE + quo8);
          state_d = ST_VOL_MUL;
        end
      end
      ST_VOL_MUL: begin
        mul_a   = MUL_W'(mag_e);
        mul_b   = MUL_W'(vol_q);
        go_d    = 1'b1;
        state_d = ST_VOL_DIV;
      end
      ST_VOL_DIV: begin
        div_req.start   = go_q;
        div_req.num     = DIV_NUM_W'(prod);
        div_req.den     = DIV_DEN_W'(PCT);
        div_req.top_bit = DIV_CNT_W'(VOL_DIV_BITS - 1);
        if (div_rsp.done) begin
          lvl_d   = neg_e ? (CENTRE - quo8) : (CENTRE + quo8);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_level_d = lvl_q;
          // level >= 128 is the top bit
          out_spk_d   = direct_q & lvl_q[7];
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_clear) begin
      fade_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      pos_q       <= '0;
      fade_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      pos_q       <= pos_d;
      fade_ok_q   <= fade_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_cur_q   <= pos_cur_d;
    smp_q       <= smp_d;
    last_q      <= last_d;
    env_q       <= env_d;
    lvl_q       <= lvl_d;
    fade_q      <= fade_d;
    out_level_q <= out_level_d;
    out_spk_q   <= out_spk_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_level_q;
  assign m_axis_tuser  = out_spk_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/pfv_div.sv =====
// pfv_div: shared restoring divider, one quotient bit per cycle
// depends on pfv_pkg for the request and response structs

module pfv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfv_pkg::div_req_t req_i,
  output pfv_pkg::div_rsp_t rsp_o
);
  import pfv_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, num_q[cnt_q]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.top_bit;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the difference fits
      rem_d = fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/pfv_mul.sv =====
// pfv_mul: shared unsigned multiplier with a registered product
// depends on pfv_pkg for operand and product widths

module pfv_mul (
  input  logic                         clk_i,
  input  logic [pfv_pkg::MUL_W-1:0]    a_i,
  input  logic [pfv_pkg::MUL_W-1:0]    b_i,
  output logic [pfv_pkg::PROD_W-1:0]   p_o
);
  import pfv_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/pfv_checker.sv =====
// pfv_checker: port-level assertions for pcm_fade_and_volume_top
// depends on pfv_pkg; bound to the top level at the end of this file

module pfv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [pfv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [pfv_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [7:0]                    m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import pfv_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one request at a time: accepting one drops ready
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a request");

  // speaker drive only with the level in the upper half
  a_spk_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7])
    else $error("speaker high with level below 128");

  // a new result only appears while a request was being worked on
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a request in flight");

endmodule

bind pcm_fade_and_volume_top pfv_checker u_pfv_checker (.*);
